// ===== rtl/prm_pkg.sv =====
// Shared types, constants and helper functions for the plasticity return mapping pipeline.
// Used by prm_front, prm_div, prm_back and the top level; depends on nothing.
package prm_pkg;

    localparam int DIV_STAGES = 12;
    localparam int DIV_STEP   = 4;

    localparam logic [2:0] REG_ELASTIC   = 3'd0;
    localparam logic [2:0] REG_YIELD     = 3'd1;
    localparam logic [2:0] REG_ISOTROPIC = 3'd2;
    localparam logic [2:0] REG_KINEMATIC = 3'd3;
    localparam logic [2:0] REG_TOLERANCE = 3'd4;

    localparam logic [19:0] RST_ELASTIC   = 20'd200000;
    localparam logic [39:0] RST_YIELD     = 40'd262144000;
    localparam logic [19:0] RST_ISOTROPIC = 20'd3000;
    localparam logic [19:0] RST_KINEMATIC = 20'd5000;
    localparam logic [19:0] RST_TOLERANCE = 20'd0;

    localparam logic signed [51:0] MAX47_S = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] MIN48_S = 52'shF_8000_0000_0000;
    localparam logic [46:0]        MAX47_U = 47'h7FFFFFFFFFFF;

    typedef struct packed {
        logic [19:0] e;
        logic [39:0] sy;
        logic [19:0] h;
        logic [19:0] k;
        logic [19:0] tol;
    } cfg_t;

    typedef struct packed {
        logic signed [47:0] eps;
        logic signed [47:0] ep;
        logic signed [47:0] beta;
        logic [46:0]        alpha;
        logic [46:0]        dis;
        logic               neg;
        logic [48:0]        mag;
        logic [44:0]        pe0;
        logic [43:0]        pe1;
        logic [43:0]        ph0;
        logic [42:0]        ph1;
        logic [40:0]        ehk;
        logic signed [49:0] str;
        logic [47:0]        rad;
        logic signed [51:0] ftr;
        logic signed [47:0] trial;
        logic               plastic;
        logic               dir_neg;
        logic [21:0]        den;
        logic               big;
        logic [21:0]        rem;
        logic [21:0]        remt;
        logic [47:0]        num;
        logic [47:0]        numt;
        logic [47:0]        q;
        logic [47:0]        qt;
        logic [46:0]        inc;
        logic [46:0]        tangent;
        logic [43:0]        pk0;
        logic [42:0]        pk1;
        logic [43:0]        pi0;
        logic [42:0]        pi1;
        logic [43:0]        ps00;
        logic [42:0]        ps01;
        logic [43:0]        ps10;
        logic [42:0]        ps11;
        logic [46:0]        kb;
        logic [46:0]        es;
        logic [46:0]        de;
        logic signed [47:0] nep;
        logic signed [47:0] nbeta;
        logic signed [47:0] stress;
        logic [46:0]        nalpha;
        logic [46:0]        ndis;
        logic [48:0]        absd;
        logic signed [47:0] fin;
    } pipe_t;

    function automatic logic signed [47:0] sat_s48(input logic signed [51:0] v);
        logic signed [51:0] r;
        r = v;
        if (v > MAX47_S) r = MAX47_S;
        else if (v < MIN48_S) r = MIN48_S;
        return r[47:0];
    endfunction

    function automatic logic [46:0] sat_u47(input logic signed [51:0] v);
        logic [46:0] r;
        r = v[46:0];
        if (v > MAX47_S) r = MAX47_U;
        else if (v < 52'sd0) r = 47'd0;
        return r;
    endfunction

    // {quotient bit, new remainder}
    function automatic logic [22:0] div_step(input logic [21:0] rem, input logic nb,
                                             input logic [21:0] den);
        logic [22:0] t;
        logic [22:0] r;
        t = {rem, nb};
        if (t >= {1'b0, den}) r = {1'b1, 22'(t - {1'b0, den})};
        else r = {1'b0, t[21:0]};
        return r;
    endfunction

endpackage

// ===== rtl/plasticity_return_mapping.sv =====
// Top level of the 1-D return mapping with linear combined hardening: register file and pipeline.
// Depends on prm_pkg, prm_front, prm_div and prm_back.
//
// Fully pipelined: one integration point is taken on every cycle that start is high (busy stays
// low), and its result appears with a one-cycle done strobe, in input order. The pipeline is the
// 12-stage divider (four quotient bits per stage) that forms the plastic increment and tangent,
// plus six front and seven back stages for the multiplies and updates. Results cannot be held
// off; registers must be written only while no item is in flight.
module plasticity_return_mapping (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [47:0]  total_strain,
    input  logic signed [47:0]  old_plastic_strain,
    input  logic signed [47:0]  old_backstress,
    input  logic [46:0]         old_accumulated_strain,
    input  logic [46:0]         old_dissipated_energy,
    output logic                done,
    output logic signed [47:0]  new_plastic_strain,
    output logic signed [47:0]  new_backstress,
    output logic [46:0]         new_accumulated_strain,
    output logic [46:0]         new_dissipated_energy,
    output logic signed [47:0]  stress_out,
    output logic [46:0]         tangent_out,
    output logic [46:0]         plastic_step,
    output logic signed [47:0]  trial_yield_value,
    output logic signed [47:0]  final_yield_value,
    output logic                yielded_flag,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    prm_pkg::cfg_t  cfg_reg;
    prm_pkg::pipe_t in_item;
    prm_pkg::pipe_t fr_item, dv_item, bk_item;
    logic fr_valid, dv_valid, bk_valid;
    logic wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.e   <= prm_pkg::RST_ELASTIC;
            cfg_reg.sy  <= prm_pkg::RST_YIELD;
            cfg_reg.h   <= prm_pkg::RST_ISOTROPIC;
            cfg_reg.k   <= prm_pkg::RST_KINEMATIC;
            cfg_reg.tol <= prm_pkg::RST_TOLERANCE;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                prm_pkg::REG_ELASTIC:   cfg_reg.e   <= pwdata[19:0];
                prm_pkg::REG_YIELD:     cfg_reg.sy  <= pwdata[39:0];
                prm_pkg::REG_ISOTROPIC: cfg_reg.h   <= pwdata[19:0];
                prm_pkg::REG_KINEMATIC: cfg_reg.k   <= pwdata[19:0];
                prm_pkg::REG_TOLERANCE: cfg_reg.tol <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            prm_pkg::REG_ELASTIC:   prdata = {44'b0, cfg_reg.e};
            prm_pkg::REG_YIELD:     prdata = {24'b0, cfg_reg.sy};
            prm_pkg::REG_ISOTROPIC: prdata = {44'b0, cfg_reg.h};
            prm_pkg::REG_KINEMATIC: prdata = {44'b0, cfg_reg.k};
            prm_pkg::REG_TOLERANCE: prdata = {44'b0, cfg_reg.tol};
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        in_item       = '0;
        in_item.eps   = total_strain;
        in_item.ep    = old_plastic_strain;
        in_item.beta  = old_backstress;
        in_item.alpha = old_accumulated_strain;
        in_item.dis   = old_dissipated_energy;
    end

    prm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (start && !busy),
        .in_item   (in_item),
        .out_valid (fr_valid),
        .out_item  (fr_item)
    );

    prm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    prm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .out_valid (bk_valid),
        .out_item  (bk_item)
    );

    assign done                   = bk_valid;
    assign new_plastic_strain     = bk_item.nep;
    assign new_backstress         = bk_item.nbeta;
    assign new_accumulated_strain = bk_item.nalpha;
    assign new_dissipated_energy  = bk_item.ndis;
    assign stress_out             = bk_item.stress;
    assign tangent_out            = bk_item.tangent;
    assign plastic_step           = bk_item.inc;
    assign trial_yield_value      = bk_item.trial;
    assign final_yield_value      = bk_item.fin;
    assign yielded_flag           = bk_item.plastic;

endmodule

// ===== rtl/prm_front.sv =====
// Front stages: strain difference, elastic trial stress, yield radius, trial yield test, divider setup.
// Depends on prm_pkg.
module prm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  prm_pkg::cfg_t   cfg,
    input  logic            in_valid,
    input  prm_pkg::pipe_t  in_item,
    output logic            out_valid,
    output prm_pkg::pipe_t  out_item
);

    prm_pkg::pipe_t a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    prm_pkg::pipe_t b_next, c_next, d_next, e_next, f_next;
    logic [5:0] vld_reg;

    logic signed [48:0] diff;
    logic [68:0] prod_e;
    logic [66:0] prod_h;
    logic [48:0] smag;
    logic [46:0] rnd_h;
    logic signed [50:0] rel;
    logic [50:0] absrel;
    logic [21:0] den;
    logic [50:0] fmag;

    always_comb
    begin
        b_next = a_reg;
        diff = {a_reg.eps[47], a_reg.eps} - {a_reg.ep[47], a_reg.ep};
        b_next.neg = diff[48];
        b_next.mag = diff[48] ? 49'(-diff) : 49'(diff);
    end

    always_comb
    begin
        c_next = b_reg;
        c_next.pe0 = 45'(cfg.e) * 45'(b_reg.mag[24:0]);
        c_next.pe1 = 44'(cfg.e) * 44'(b_reg.mag[48:25]);
        c_next.ph0 = 44'(cfg.h) * 44'(b_reg.alpha[23:0]);
        c_next.ph1 = 43'(cfg.h) * 43'(b_reg.alpha[46:24]);
        c_next.ehk = 41'(cfg.e) * 41'(21'(cfg.h) + 21'(cfg.k));
    end

    always_comb
    begin
        d_next = c_reg;
        prod_e = {24'b0, c_reg.pe0} + {c_reg.pe1, 25'b0} + 69'd524288;
        smag = prod_e[68:20];
        d_next.str = c_reg.neg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
        prod_h = {23'b0, c_reg.ph0} + {c_reg.ph1, 24'b0} + 67'd524288;
        rnd_h = prod_h[66:20];
        d_next.rad = {8'b0, cfg.sy} + {1'b0, rnd_h};
    end

    always_comb
    begin
        e_next = d_reg;
        rel = {d_reg.str[49], d_reg.str} - {{3{d_reg.beta[47]}}, d_reg.beta};
        absrel = rel[50] ? 51'(-rel) : 51'(rel);
        e_next.dir_neg = rel[50];
        e_next.ftr = $signed({1'b0, absrel}) - $signed({4'b0, d_reg.rad});
        e_next.plastic = e_next.ftr > $signed({32'b0, cfg.tol});
        e_next.trial = prm_pkg::sat_s48(e_next.ftr);
    end

    always_comb
    begin
        f_next = e_reg;
        den = 22'(cfg.e) + 22'(cfg.h) + 22'(cfg.k);
        if (den == 22'd0)
        begin
            den = 22'd1;
        end
        fmag = e_reg.ftr[50:0];
        f_next.den = den;
        f_next.big = fmag >= {2'b0, den, 27'b0};
        f_next.rem = fmag[49:28];
        f_next.num = {fmag[27:0], 20'b0};
        f_next.remt = {9'b0, e_reg.ehk[40:28]};
        f_next.numt = {e_reg.ehk[27:0], 20'b0};
        f_next.q = '0;
        f_next.qt = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= in_item;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        f_reg <= f_next;
    end

    assign out_valid = vld_reg[5];
    assign out_item  = f_reg;

endmodule

// ===== rtl/prm_div.sv =====
// Pipelined restoring divider: plastic increment and plastic tangent lanes, four bits per stage.
// Depends on prm_pkg.
module prm_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  prm_pkg::pipe_t  in_item,
    output logic            out_valid,
    output prm_pkg::pipe_t  out_item
);

    prm_pkg::pipe_t stage_reg  [prm_pkg::DIV_STAGES];
    prm_pkg::pipe_t stage_next [prm_pkg::DIV_STAGES];
    logic [prm_pkg::DIV_STAGES-1:0] vld_reg;

    genvar g;
    generate
        for (g = 0; g < prm_pkg::DIV_STAGES; g++)
        begin : g_stage
            prm_pkg::pipe_t src;

            if (g == 0)
            begin : g_first
                assign src = in_item;
            end
            else
            begin : g_rest
                assign src = stage_reg[g-1];
            end

            always_comb
            begin
                logic [22:0] sm;
                logic [22:0] st;
                stage_next[g] = src;
                for (int j = 0; j < prm_pkg::DIV_STEP; j++)
                begin
                    sm = prm_pkg::div_step(stage_next[g].rem, stage_next[g].num[47],
                                           stage_next[g].den);
                    st = prm_pkg::div_step(stage_next[g].remt, stage_next[g].numt[47],
                                           stage_next[g].den);
                    stage_next[g].rem  = sm[21:0];
                    stage_next[g].remt = st[21:0];
                    stage_next[g].num  = {stage_next[g].num[46:0], 1'b0};
                    stage_next[g].numt = {stage_next[g].numt[46:0], 1'b0};
                    stage_next[g].q    = {stage_next[g].q[46:0], sm[22]};
                    stage_next[g].qt   = {stage_next[g].qt[46:0], st[22]};
                end
            end

            always_ff @(posedge clk)
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[prm_pkg::DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[prm_pkg::DIV_STAGES-1];
    assign out_item  = stage_reg[prm_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/prm_back.sv =====
// Back stages: increment rounding, hardening products, state update, final yield value.
// Depends on prm_pkg.
module prm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  prm_pkg::cfg_t   cfg,
    input  logic            in_valid,
    input  prm_pkg::pipe_t  in_item,
    output logic            out_valid,
    output prm_pkg::pipe_t  out_item
);

    prm_pkg::pipe_t g_reg, h_reg, i_reg, j_reg, k_reg, l_reg, m_reg;
    prm_pkg::pipe_t g_next, h_next, i_next, j_next, k_next, l_next, m_next;
    logic [6:0] vld_reg;

    logic [48:0] qinc;
    logic [47:0] qtan;
    logic [66:0] sum_k;
    logic [66:0] sum_e;
    logic [86:0] sum_s;
    logic [66:0] sum_h;
    logic signed [51:0] dv;

    always_comb
    begin
        g_next = in_item;
        qinc = {1'b0, in_item.q} + 49'({in_item.rem, 1'b0} >= {1'b0, in_item.den});
        qtan = in_item.qt + 48'({in_item.remt, 1'b0} >= {1'b0, in_item.den});
        if (!in_item.plastic)
        begin
            g_next.inc = '0;
            g_next.tangent = {7'b0, cfg.e, 20'b0};
        end
        else
        begin
            if (in_item.big || qinc > {2'b0, prm_pkg::MAX47_U})
            begin
                g_next.inc = prm_pkg::MAX47_U;
            end
            else
            begin
                g_next.inc = qinc[46:0];
            end
            g_next.tangent = qtan[46:0];
        end
    end

    always_comb
    begin
        h_next = g_reg;
        h_next.pk0  = 44'(cfg.k) * 44'(g_reg.inc[23:0]);
        h_next.pk1  = 43'(cfg.k) * 43'(g_reg.inc[46:24]);
        h_next.pi0  = 44'(cfg.e) * 44'(g_reg.inc[23:0]);
        h_next.pi1  = 43'(cfg.e) * 43'(g_reg.inc[46:24]);
        h_next.ps00 = 44'(cfg.sy[19:0]) * 44'(g_reg.inc[23:0]);
        h_next.ps01 = 43'(cfg.sy[19:0]) * 43'(g_reg.inc[46:24]);
        h_next.ps10 = 44'(cfg.sy[39:20]) * 44'(g_reg.inc[23:0]);
        h_next.ps11 = 43'(cfg.sy[39:20]) * 43'(g_reg.inc[46:24]);
    end

    always_comb
    begin
        i_next = h_reg;
        sum_k = {23'b0, h_reg.pk0} + {h_reg.pk1, 24'b0} + 67'd524288;
        sum_e = {23'b0, h_reg.pi0} + {h_reg.pi1, 24'b0} + 67'd524288;
        sum_s = {43'b0, h_reg.ps00} + {20'b0, h_reg.ps01, 24'b0}
              + {23'b0, h_reg.ps10, 20'b0} + {h_reg.ps11, 44'b0} + 87'h8000000000;
        i_next.kb = sum_k[66:20];
        i_next.es = sum_e[66:20];
        i_next.de = sum_s[86:40];
    end

    always_comb
    begin
        j_next = i_reg;
        if (i_reg.dir_neg)
        begin
            j_next.nep = prm_pkg::sat_s48($signed({{4{i_reg.ep[47]}}, i_reg.ep})
                                        - $signed({5'b0, i_reg.inc}));
            j_next.nbeta = prm_pkg::sat_s48($signed({{4{i_reg.beta[47]}}, i_reg.beta})
                                          - $signed({5'b0, i_reg.kb}));
            j_next.stress = prm_pkg::sat_s48($signed({{2{i_reg.str[49]}}, i_reg.str})
                                           + $signed({5'b0, i_reg.es}));
        end
        else
        begin
            j_next.nep = prm_pkg::sat_s48($signed({{4{i_reg.ep[47]}}, i_reg.ep})
                                        + $signed({5'b0, i_reg.inc}));
            j_next.nbeta = prm_pkg::sat_s48($signed({{4{i_reg.beta[47]}}, i_reg.beta})
                                          + $signed({5'b0, i_reg.kb}));
            j_next.stress = prm_pkg::sat_s48($signed({{2{i_reg.str[49]}}, i_reg.str})
                                           - $signed({5'b0, i_reg.es}));
        end
        j_next.nalpha = prm_pkg::sat_u47($signed({5'b0, i_reg.alpha})
                                       + $signed({5'b0, i_reg.inc}));
        j_next.ndis = prm_pkg::sat_u47($signed({5'b0, i_reg.dis})
                                     + $signed({5'b0, i_reg.de}));
    end

    always_comb
    begin
        k_next = j_reg;
        k_next.ph0 = 44'(cfg.h) * 44'(j_reg.nalpha[23:0]);
        k_next.ph1 = 43'(cfg.h) * 43'(j_reg.nalpha[46:24]);
        dv = $signed({{4{j_reg.stress[47]}}, j_reg.stress})
           - $signed({{4{j_reg.nbeta[47]}}, j_reg.nbeta});
        k_next.absd = dv[51] ? 49'(-dv) : 49'(dv);
    end

    always_comb
    begin
        l_next = k_reg;
        sum_h = {23'b0, k_reg.ph0} + {k_reg.ph1, 24'b0} + 67'd524288;
        l_next.rad = {8'b0, cfg.sy} + {1'b0, sum_h[66:20]};
    end

    always_comb
    begin
        m_next = l_reg;
        m_next.fin = prm_pkg::sat_s48($signed({3'b0, l_reg.absd}) - $signed({4'b0, l_reg.rad}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        h_reg <= h_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        l_reg <= l_next;
        m_reg <= m_next;
    end

    assign out_valid = vld_reg[6];
    assign out_item  = m_reg;

endmodule

// ===== rtl/prm_checker.sv =====
// Port-level checker for plasticity_return_mapping, attached by bind.
// Depends on the top level's port names only.
module prm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        yielded_flag,
    input logic [46:0] plastic_step
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) busy == 1'b0)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##25 done)
        else $error("result missing after transfer");

    a_elastic_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !yielded_flag) |-> (plastic_step == 47'd0))
        else $error("increment on an elastic result");

endmodule

bind plasticity_return_mapping prm_checker u_chk (.*);
